FILE: rtl/sti_pkg.sv
// ----------------------------------------------------------------------------
// sti_pkg: shared types and constants for segment/triangle intersection
// coordinate and fixed point widths, request, job and result structs, relation codes
// ----------------------------------------------------------------------------
`default_nettype none
package sti_pkg;
	localparam int COORD_WIDTH = 16;
	localparam int FRAC_BITS   = 16;
	localparam int FIELD_W     = 48;
	localparam int DIFF_W      = COORD_WIDTH + 1;
	localparam int CROSS_W     = 2 * DIFF_W + 2;
	localparam int DOT_W       = CROSS_W + DIFF_W + 3;
	localparam int DIV_W       = DOT_W + FRAC_BITS;
	localparam int QBITS       = 34;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	localparam logic [1:0] REL_SINGLE     = 2'd0;
	localparam logic [1:0] REL_IN_PLANE   = 2'd1;
	localparam logic [1:0] REL_NONE       = 2'd2;
	localparam logic [1:0] REL_DEGENERATE = 2'd3;

	typedef struct packed {
		logic [FIELD_W-1:0] tri_vertex_a;
		logic [FIELD_W-1:0] tri_vertex_b;
		logic [FIELD_W-1:0] tri_vertex_c;
		logic [FIELD_W-1:0] seg_start;
		logic [FIELD_W-1:0] seg_end;
	} req_t;

	typedef struct packed {
		logic               hit;
		logic [1:0]         plane_relation;
		logic signed [31:0] seg_param;
		logic signed [31:0] bary_first;
		logic signed [31:0] bary_second;
	} rsp_t;

	typedef struct packed {
		logic                    degen;
		logic signed [DOT_W-1:0] num_t;
		logic signed [DOT_W-1:0] num_a;
		logic signed [DOT_W-1:0] num_b;
		logic signed [DOT_W-1:0] den;
	} job_t;

	function automatic logic signed [DIFF_W-1:0] coord(input logic [FIELD_W-1:0] w,
		input int i);
		logic [COORD_WIDTH-1:0] raw;
		raw = COORD_WIDTH'(w >> (i * COORD_WIDTH));
		return DIFF_W'($signed(raw));
	endfunction
endpackage
`default_nettype wire

FILE: rtl/sti_front.sv
// ----------------------------------------------------------------------------
// sti_front: geometry front end
// differences, cross products and dot products over three registered stages
// ----------------------------------------------------------------------------
`default_nettype none
module sti_front import sti_pkg::*; (
	input  wire  clk,
	input  wire  arst_n,
	input  req_t req,
	input  wire  req_valid,
	input  wire  advance,
	output logic job_valid,
	output job_t job
);
	typedef logic signed [DIFF_W-1:0] d_t;
	typedef logic signed [CROSS_W-1:0] c_t;

	logic v_s1, v_s2;
	d_t ab_s1 [3], ac_s1 [3], sa_s1 [3], dd_s1 [3], pa_s1 [3], pb_s1 [3], pc_s1 [3];
	c_t n_s2 [3], xbc_s2 [3], xca_s2 [3];
	d_t sa_s2 [3], dd_s2 [3];

	function automatic c_t mul(input d_t x, input d_t y);
		return CROSS_W'(x) * CROSS_W'(y);
	endfunction

	function automatic logic signed [DOT_W-1:0] dotp(input c_t a [3], input d_t b [3]);
		logic signed [DOT_W-1:0] s;
		s = '0;
		for (int i = 0; i < 3; i++) s = s + DOT_W'(a[i]) * DOT_W'(b[i]);
		return s;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; job_valid <= 1'b0;
		end else if (advance) begin
			v_s1 <= req_valid; v_s2 <= v_s1; job_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < 3; i++) begin
				ab_s1[i] <= coord(req.tri_vertex_b, i) - coord(req.tri_vertex_a, i);
				ac_s1[i] <= coord(req.tri_vertex_c, i) - coord(req.tri_vertex_a, i);
				sa_s1[i] <= coord(req.seg_start, i) - coord(req.tri_vertex_a, i);
				dd_s1[i] <= coord(req.seg_end, i) - coord(req.seg_start, i);
				pa_s1[i] <= coord(req.tri_vertex_a, i) - coord(req.seg_start, i);
				pb_s1[i] <= coord(req.tri_vertex_b, i) - coord(req.seg_start, i);
				pc_s1[i] <= coord(req.tri_vertex_c, i) - coord(req.seg_start, i);
			end
			for (int i = 0; i < 3; i++) begin
				n_s2[i]   <= mul(ab_s1[(i+1)%3], ac_s1[(i+2)%3])
				           - mul(ab_s1[(i+2)%3], ac_s1[(i+1)%3]);
				xbc_s2[i] <= mul(pb_s1[(i+1)%3], pc_s1[(i+2)%3])
				           - mul(pb_s1[(i+2)%3], pc_s1[(i+1)%3]);
				xca_s2[i] <= mul(pc_s1[(i+1)%3], pa_s1[(i+2)%3])
				           - mul(pc_s1[(i+2)%3], pa_s1[(i+1)%3]);
			end
			sa_s2 <= sa_s1;
			dd_s2 <= dd_s1;
			job.degen <= (n_s2[0] == '0) && (n_s2[1] == '0) && (n_s2[2] == '0);
			job.num_t <= -dotp(n_s2, sa_s2);
			job.den   <= dotp(n_s2, dd_s2);
			job.num_a <= dotp(xbc_s2, dd_s2);
			job.num_b <= dotp(xca_s2, dd_s2);
		end
	end
endmodule
`default_nettype wire

FILE: rtl/sti_queue.sv
// ----------------------------------------------------------------------------
// sti_queue: small fifo between front and back
// registered entries, empty flag derived from the occupancy count
// ----------------------------------------------------------------------------
`default_nettype none
module sti_queue import sti_pkg::*; (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  push,
	input  job_t wdata,
	input  wire  pop,
	output job_t rdata,
	output logic empty,
	output logic [QPTR_W:0] count
);
	job_t mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;

	assign empty = (count == '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; count <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue popped while empty");
	assert property (@(posedge clk) disable iff (!arst_n)
		count <= (QPTR_W+1)'(QUEUE_DEPTH))
		else $error("queue overflow");
endmodule
`default_nettype wire

FILE: rtl/sti_divider.sv
// ----------------------------------------------------------------------------
// sti_divider: pipelined restoring divider for saturated Q16.16 quotients
// one quotient bit per stage, magnitude only, sign and saturation at the end
// ----------------------------------------------------------------------------
`default_nettype none
module sti_divider import sti_pkg::*; (
	input  wire  clk,
	input  wire  en,
	input  logic signed [DOT_W-1:0] num,
	input  logic signed [DOT_W-1:0] den,
	output logic signed [31:0] quo
);
	// quotient bits below QBITS are kept exactly; anything above is folded
	// into an overflow flag by a pre-compare
	localparam int NS = QBITS;
	typedef logic [DIV_W-1:0] u_t;

	u_t rem_in, dsh_in;
	logic big_in, neg_in;
	u_t rem_q [NS];
	u_t dsh_q [NS];
	logic [QBITS-1:0] q_q [NS];
	logic big_q [NS], neg_q [NS];

	always_comb begin
		rem_in = u_t'(num[DOT_W-1] ? -num : num) << FRAC_BITS;
		dsh_in = u_t'(den[DOT_W-1] ? -den : den);
		big_in = (rem_in >> QBITS) >= dsh_in;
		neg_in = num[DOT_W-1] ^ den[DOT_W-1];
	end

	for (genvar k = 0; k < NS; k++) begin : g_st
		localparam int B = NS - 1 - k;
		u_t rem_p, dsh_p;
		logic [QBITS-1:0] q_p;
		logic big_p, neg_p;
		if (k == 0) begin : g_in
			assign rem_p = rem_in;
			assign dsh_p = dsh_in;
			assign q_p   = '0;
			assign big_p = big_in;
			assign neg_p = neg_in;
		end else begin : g_prev
			assign rem_p = rem_q[k-1];
			assign dsh_p = dsh_q[k-1];
			assign q_p   = q_q[k-1];
			assign big_p = big_q[k-1];
			assign neg_p = neg_q[k-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if ((rem_p >> B) >= dsh_p) begin
					rem_q[k] <= rem_p - (dsh_p << B);
					q_q[k]   <= q_p | (QBITS'(1) << B);
				end else begin
					rem_q[k] <= rem_p;
					q_q[k]   <= q_p;
				end
				dsh_q[k] <= dsh_p;
				big_q[k] <= big_p;
				neg_q[k] <= neg_p;
			end
		end
	end

	always_comb begin
		logic [QBITS-1:0] q;
		q = q_q[NS-1];
		if (neg_q[NS-1]) begin
			if (big_q[NS-1] || q > QBITS'(34'h080000000)) quo = 32'sh80000000;
			else quo = 32'(-q);
		end else begin
			if (big_q[NS-1] || q > QBITS'(34'h07FFFFFFF)) quo = 32'sh7FFFFFFF;
			else quo = 32'(q);
		end
	end
endmodule
`default_nettype wire

FILE: rtl/sti_back.sv
// ----------------------------------------------------------------------------
// sti_back: classification and division back end
// three dividers in lockstep, final range checks, output register
// ----------------------------------------------------------------------------
`default_nettype none
module sti_back import sti_pkg::*; (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  job_valid,
	input  job_t job,
	input  wire  advance,
	output logic out_valid,
	output rsp_t out_rsp
);
	localparam int NS = QBITS;
	localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

	logic v_q [NS];
	logic [1:0] rel_q [NS];
	logic [1:0] rel_in;
	logic signed [31:0] t, a, b, c;
	logic signed [DOT_W-1:0] dsafe;
	rsp_t rsp_d;

	assign dsafe = (job.den == '0) ? DOT_W'(1) : job.den;

	sti_divider u_div_t (.clk, .en(advance), .num(job.num_t), .den(dsafe), .quo(t));
	sti_divider u_div_a (.clk, .en(advance), .num(job.num_a), .den(dsafe), .quo(a));
	sti_divider u_div_b (.clk, .en(advance), .num(job.num_b), .den(dsafe), .quo(b));

	always_comb begin
		if (job.degen) rel_in = REL_DEGENERATE;
		else if (job.den == '0) rel_in = (job.num_t == '0) ? REL_IN_PLANE : REL_NONE;
		else rel_in = REL_SINGLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NS; k++) v_q[k] <= 1'b0;
		end else if (advance) begin
			v_q[0] <= job_valid;
			for (int k = 1; k < NS; k++) v_q[k] <= v_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rel_q[0] <= rel_in;
			for (int k = 1; k < NS; k++) rel_q[k] <= rel_q[k-1];
		end
	end

	assign c = ONE - a - b;

	always_comb begin
		rsp_d = '0;
		if (rel_q[NS-1] != REL_SINGLE) begin
			rsp_d.plane_relation = rel_q[NS-1];
		end else if (t < 0 || t > ONE) begin
			rsp_d.plane_relation = REL_NONE;
			rsp_d.seg_param = t;
		end else begin
			rsp_d.plane_relation = REL_SINGLE;
			rsp_d.seg_param = t;
			rsp_d.bary_first = a;
			rsp_d.bary_second = b;
			rsp_d.hit = a >= 0 && a <= ONE && b >= 0 && b <= ONE &&
			            c >= 0 && c <= ONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (advance) out_valid <= v_q[NS-1];
	end

	always_ff @(posedge clk) begin
		if (advance) out_rsp <= rsp_d;
	end
endmodule
`default_nettype wire

FILE: rtl/segment_triangle_intersection.sv
// ----------------------------------------------------------------------------
// segment_triangle_intersection: segment/triangle test, one per cycle if ready
// front computes plane and triple products, back divides and classifies
// ----------------------------------------------------------------------------
// channel  direction  handshake          payload
// req      in         req_valid/ready    req_t  (three vertices, segment)
// rsp      out        rsp_valid/ready    rsp_t  (hit, relation, t, a, b)
//
// one request per cycle sustained while rsp_ready is high; each request
// passes 3 front stages, queue, 34 divider stages and the result register
// the front stalls only when the queue is full and the back is stalled
// the back pipeline advances whenever its result register is free or taken
// reset clears all valid flags and queue pointers; payload is not reset
// ----------------------------------------------------------------------------
`default_nettype none
module segment_triangle_intersection import sti_pkg::*; (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  wire  rsp_ready,
	output rsp_t rsp
);
	logic f_adv, b_adv, jv, q_empty;
	job_t fjob, qjob;
	logic [QPTR_W:0] q_count;

	// back pipeline moves when its output slot is empty or being drained
	assign b_adv = !rsp_valid || rsp_ready;

	// front moves while the queue has a free slot or the back drains it
	assign f_adv = q_count <= (QPTR_W+1)'(QUEUE_DEPTH - 1) || b_adv;
	assign req_ready = f_adv;

	sti_front u_front (
		.clk, .arst_n, .req, .req_valid(req_valid), .advance(f_adv),
		.job_valid(jv), .job(fjob)
	);

	// push when a front result leaves stage three
	sti_queue u_queue (
		.clk, .arst_n, .push(f_adv && jv), .wdata(fjob),
		.pop(b_adv && !q_empty), .rdata(qjob), .empty(q_empty), .count(q_count)
	);

	sti_back u_back (
		.clk, .arst_n, .job_valid(!q_empty), .job(qjob), .advance(b_adv),
		.out_valid(rsp_valid), .out_rsp(rsp)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid)
		else $error("result dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> $stable(rsp))
		else $error("result changed while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		(f_adv && jv) |-> (q_count < (QPTR_W+1)'(QUEUE_DEPTH) || b_adv))
		else $error("push into full queue");
endmodule
`default_nettype wire
